FILE: hw/rtl/arima_pkg.sv
// Shared types, constants and saturation helpers for the seasonal ARIMA predictor.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps

package arima_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 16;
    localparam int PRODUCT_W   = SAMPLE_W + WEIGHT_W;
    localparam int FRAC_SHIFT  = 14;
    localparam int TERM_W      = PRODUCT_W - FRAC_SHIFT;
    localparam int ACC_W       = 21;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_AR_LAG1     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AR_LAG2     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MA_LAG1     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MA_LAG2     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SEASONAL_AR = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SEASONAL_MA = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL       = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_DIFF_EN     = 3'd7;

    // Register values after reset.
    localparam weight_t RST_AR_LAG1     = 16'sd8192;
    localparam weight_t RST_AR_LAG2     = -16'sd4915;
    localparam weight_t RST_MA_LAG1     = 16'sd3277;
    localparam weight_t RST_MA_LAG2     = 16'sd1638;
    localparam weight_t RST_SEASONAL_AR = 16'sd4915;
    localparam weight_t RST_SEASONAL_MA = -16'sd3277;
    localparam sample_t RST_LEVEL       = 16'sd5504;
    localparam logic    RST_DIFF_EN     = 1'b1;

    localparam acc_t SAT_MAX = acc_t'(32767);
    localparam acc_t SAT_MIN = -acc_t'(32768);

    typedef struct packed {
        weight_t ar_lag1;
        weight_t ar_lag2;
        weight_t ma_lag1;
        weight_t ma_lag2;
        weight_t seasonal_ar_weight;
        weight_t seasonal_ma_weight;
        sample_t level_offset;
        logic    difference_enable;
    } cfg_t;

    typedef struct packed {
        sample_t previous_raw;
        sample_t diff_lag1;
        sample_t diff_lag2;
        sample_t err_lag1;
        sample_t err_lag2;
        sample_t season_diff;
        sample_t season_err;
    } hist_t;

    function automatic sample_t sat16(input acc_t v);
        sample_t r;
        if (v > SAT_MAX) begin
            r = sample_t'(SAT_MAX);
        end
        else if (v < SAT_MIN) begin
            r = sample_t'(SAT_MIN);
        end
        else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic clips16(input acc_t v);
        return (v > SAT_MAX) || (v < SAT_MIN);
    endfunction

endpackage

FILE: hw/rtl/arima_in_if.sv
// Sample stream interface: valid/ready handshake carrying one Q8.8 sample.
// Depends on arima_pkg for the sample type.
`timescale 1ns / 1ps

interface arima_in_if;
    logic              valid;
    logic              ready;
    arima_pkg::sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: hw/rtl/arima_out_if.sv
// Forecast stream interface: valid/ready handshake carrying a prediction and clip flag.
// Depends on arima_pkg for the sample type.
`timescale 1ns / 1ps

interface arima_out_if;
    logic               valid;
    logic               ready;
    arima_pkg::sample_t prediction;
    logic               saturated;

    modport source (output valid, output prediction, output saturated, input ready);
    modport sink   (input valid, input prediction, input saturated, output ready);
endinterface

FILE: hw/rtl/arima_cfg_regs.sv
// Configuration register file of the predictor, written through a plain write port.
// Depends on arima_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module arima_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [arima_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [arima_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output arima_pkg::cfg_t                    cfg
);
    import arima_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_AR_LAG1:     cfg_next.ar_lag1            = weight_t'(cfg_wdata);
                REG_AR_LAG2:     cfg_next.ar_lag2            = weight_t'(cfg_wdata);
                REG_MA_LAG1:     cfg_next.ma_lag1            = weight_t'(cfg_wdata);
                REG_MA_LAG2:     cfg_next.ma_lag2            = weight_t'(cfg_wdata);
                REG_SEASONAL_AR: cfg_next.seasonal_ar_weight = weight_t'(cfg_wdata);
                REG_SEASONAL_MA: cfg_next.seasonal_ma_weight = weight_t'(cfg_wdata);
                REG_LEVEL:       cfg_next.level_offset       = sample_t'(cfg_wdata);
                REG_DIFF_EN:     cfg_next.difference_enable  = cfg_wdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ar_lag1            <= RST_AR_LAG1;
            cfg_reg.ar_lag2            <= RST_AR_LAG2;
            cfg_reg.ma_lag1            <= RST_MA_LAG1;
            cfg_reg.ma_lag2            <= RST_MA_LAG2;
            cfg_reg.seasonal_ar_weight <= RST_SEASONAL_AR;
            cfg_reg.seasonal_ma_weight <= RST_SEASONAL_MA;
            cfg_reg.level_offset       <= RST_LEVEL;
            cfg_reg.difference_enable  <= RST_DIFF_EN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/arima_history.sv
// History stores: previous raw sample, two recent differences and errors, and
// seasonal shift lines. Depends on arima_pkg for sample_t and hist_t.
`timescale 1ns / 1ps

module arima_history #(
    parameter int SEASON_LENGTH = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift_en,
    input  arima_pkg::sample_t raw_in,
    input  arima_pkg::sample_t diff_in,
    input  arima_pkg::sample_t err_in,
    output arima_pkg::hist_t   hist
);
    import arima_pkg::*;

    sample_t previous_raw_reg;
    sample_t diff_lag1_reg;
    sample_t diff_lag2_reg;
    sample_t err_lag1_reg;
    sample_t err_lag2_reg;
    sample_t season_diffs_reg [SEASON_LENGTH];
    sample_t season_errors_reg [SEASON_LENGTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_raw_reg <= '0;
            diff_lag1_reg    <= '0;
            diff_lag2_reg    <= '0;
            err_lag1_reg     <= '0;
            err_lag2_reg     <= '0;
            for (int i = 0; i < SEASON_LENGTH; i++)
            begin
                season_diffs_reg[i]  <= '0;
                season_errors_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            previous_raw_reg     <= raw_in;
            diff_lag1_reg        <= diff_in;
            diff_lag2_reg        <= diff_lag1_reg;
            err_lag1_reg         <= err_in;
            err_lag2_reg         <= err_lag1_reg;
            season_diffs_reg[0]  <= diff_in;
            season_errors_reg[0] <= err_in;
            for (int i = 1; i < SEASON_LENGTH; i++)
            begin
                season_diffs_reg[i]  <= season_diffs_reg[i-1];
                season_errors_reg[i] <= season_errors_reg[i-1];
            end
        end
    end

    // The last tap of each shift line is the entry written one season ago.
    assign hist.previous_raw = previous_raw_reg;
    assign hist.diff_lag1    = diff_lag1_reg;
    assign hist.diff_lag2    = diff_lag2_reg;
    assign hist.err_lag1     = err_lag1_reg;
    assign hist.err_lag2     = err_lag2_reg;
    assign hist.season_diff  = season_diffs_reg[SEASON_LENGTH-1];
    assign hist.season_err   = season_errors_reg[SEASON_LENGTH-1];

endmodule

FILE: hw/rtl/arima_datapath.sv
// Combinational forecast: differencing, six weighted terms plus intercept,
// saturation and error. Depends on arima_pkg for types and saturation helpers.
`timescale 1ns / 1ps

module arima_datapath (
    input  arima_pkg::sample_t sample,
    input  arima_pkg::cfg_t    cfg,
    input  arima_pkg::hist_t   hist,
    output arima_pkg::sample_t diff,
    output arima_pkg::sample_t err,
    output arima_pkg::sample_t prediction,
    output logic               saturated
);
    import arima_pkg::*;

    // Q2.14 times Q8.8, arithmetic shift right by 14 (floor), sign-extended.
    function automatic acc_t term(input weight_t w, input sample_t x);
        logic signed [PRODUCT_W-1:0] p;
        p = w * x;
        return {{(ACC_W-TERM_W){p[PRODUCT_W-1]}}, p[PRODUCT_W-1:FRAC_SHIFT]};
    endfunction

    logic signed [SAMPLE_W:0] raw_diff;
    logic signed [SAMPLE_W:0] err_wide;
    acc_t                     acc;
    logic                     pred_clip;
    logic                     err_clip;

    always_comb
    begin
        raw_diff = {sample[SAMPLE_W-1], sample}
                 - {hist.previous_raw[SAMPLE_W-1], hist.previous_raw};
        if (cfg.difference_enable)
        begin
            diff = sat16({{(ACC_W-SAMPLE_W-1){raw_diff[SAMPLE_W]}}, raw_diff});
        end
        else
        begin
            diff = sample;
        end

        acc = {{(ACC_W-SAMPLE_W){cfg.level_offset[SAMPLE_W-1]}}, cfg.level_offset}
            + term(cfg.ar_lag1, hist.diff_lag1)
            + term(cfg.ar_lag2, hist.diff_lag2)
            + term(cfg.ma_lag1, hist.err_lag1)
            + term(cfg.ma_lag2, hist.err_lag2)
            + term(cfg.seasonal_ar_weight, hist.season_diff)
            + term(cfg.seasonal_ma_weight, hist.season_err);
        prediction = sat16(acc);
        pred_clip  = clips16(acc);

        err_wide = {diff[SAMPLE_W-1], diff} - {prediction[SAMPLE_W-1], prediction};
        err      = sat16({{(ACC_W-SAMPLE_W-1){err_wide[SAMPLE_W]}}, err_wide});
        err_clip = clips16({{(ACC_W-SAMPLE_W-1){err_wide[SAMPLE_W]}}, err_wide});

        saturated = pred_clip | err_clip;
    end

endmodule

FILE: hw/rtl/arima_one_step_predictor.sv
// Top level of the seasonal ARIMA one-step predictor.
// Depends on arima_pkg, arima_in_if, arima_out_if, arima_cfg_regs, arima_history
// and arima_datapath.
`timescale 1ns / 1ps

// The predictor takes one Q8.8 sample per transaction on sample_stream and returns
// exactly one forecast transaction on forecast_stream for it, in order. It sustains
// one transaction per clock cycle while forecast_stream stays ready. A sample is held
// in the input register until the result register is empty or draining, and its
// forecast is then loaded into the result register, from which it is offered. The
// single combinational pass between those registers holds six 16x16 multiplies,
// an adder tree, saturation and the error subtraction. Each prediction is formed
// from the history as it stood before the sample, so the sample affects only the
// clip flag of its own forecast, through the error, and later forecasts. The
// seasonal stores are shift lines of SEASON_LENGTH entries that reset to zero with
// the rest of the history; no clearing pass is needed. Configuration registers are
// written through cfg_we/cfg_index/cfg_wdata and must only be changed while no
// transaction is in flight.
module arima_one_step_predictor #(
    parameter int SEASON_LENGTH = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [arima_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [arima_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    arima_in_if.sink                           sample_stream,
    arima_out_if.source                        forecast_stream
);
    import arima_pkg::*;

    cfg_t    cfg;
    hist_t   hist;
    sample_t diff;
    sample_t err;
    sample_t prediction;
    logic    saturated;

    // Input register stage.
    logic    in_valid_reg;
    logic    in_valid_next;
    sample_t sample_reg;

    // Result register stage.
    logic    out_valid_reg;
    logic    out_valid_next;
    sample_t prediction_reg;
    logic    saturated_reg;

    logic    advance;
    logic    in_take;

    // The held sample moves into the result register whenever the result register is
    // empty or its transaction completes in this cycle; the history updates at the same
    // edge, so the next sample already sees it.
    assign advance = in_valid_reg && (!out_valid_reg || forecast_stream.ready);

    // A new sample is taken whenever the input register is empty or draining.
    assign sample_stream.ready = !in_valid_reg || advance;
    assign in_take             = sample_stream.valid && sample_stream.ready;

    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (forecast_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= sample_stream.sample;
        end
        if (advance)
        begin
            prediction_reg <= prediction;
            saturated_reg  <= saturated;
        end
    end

    arima_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    arima_history #(
        .SEASON_LENGTH (SEASON_LENGTH)
    ) u_history (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (advance),
        .raw_in   (sample_reg),
        .diff_in  (diff),
        .err_in   (err),
        .hist     (hist)
    );

    arima_datapath u_datapath (
        .sample     (sample_reg),
        .cfg        (cfg),
        .hist       (hist),
        .diff       (diff),
        .err        (err),
        .prediction (prediction),
        .saturated  (saturated)
    );

    assign forecast_stream.valid      = out_valid_reg;
    assign forecast_stream.prediction = prediction_reg;
    assign forecast_stream.saturated  = saturated_reg;

endmodule

FILE: bench/arima_one_step_predictor_tb.sv
// Self-checking testbench for the seasonal ARIMA one-step predictor.
// Depends on arima_pkg, arima_in_if, arima_out_if and arima_one_step_predictor.
`timescale 1ns / 1ps

module arima_one_step_predictor_tb;
    import arima_pkg::*;

    localparam int SEASON = 12;

    // One forecast as the block should return it.
    typedef struct {
        sample_t prediction;
        logic    saturated;
    } forecast_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    arima_in_if  sample_if ();
    arima_out_if forecast_if ();

    arima_one_step_predictor #(
        .SEASON_LENGTH(SEASON)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .sample_stream   (sample_if),
        .forecast_stream (forecast_if)
    );

    always #4 clk = ~clk;

    // Samples waiting to be offered, and forecasts owed by the block in
    // the order their samples were accepted.
    sample_t   samples_to_send[$];
    forecast_t forecasts_due[$];

    // When set, the matching side of the handshake never idles. The stimulus
    // process flips these between phases so that back-to-back stretches occur.
    logic in_steady;
    logic out_steady;

    int unsigned send_gap;
    int unsigned recv_stall;
    int unsigned mismatch_count;
    int unsigned forecasts_checked;
    int unsigned clipped_seen;
    int unsigned samples_queued;
    int unsigned settings_count;

    // Mirror of the block: its registers and its history stores.
    cfg_t        model_cfg;
    sample_t     prev_raw;
    sample_t     diff_hist[2];
    sample_t     err_hist[2];
    sample_t     season_diff_mem[SEASON];
    sample_t     season_err_mem[SEASON];
    int unsigned season_slot;

    // State of the synthetic sensor series used by most random samples.
    int          walk_level;
    int          season_shape[SEASON];
    int unsigned series_tick;

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Clamp a wide value to the signed 16-bit range and tell whether it hit a rail.
    function automatic sample_t clip16(input longint v, output logic hit);
        sample_t r;
        hit = 1'b0;
        if (v > 32767) begin
            hit = 1'b1;
            r   = 16'sh7FFF;
        end
        else if (v < -32768) begin
            hit = 1'b1;
            r   = 16'sh8000;
        end
        else begin
            r = sample_t'(v);
        end
        return r;
    endfunction

    // A Q2.14 weight times a Q8.8 value, brought back to Q8.8. The arithmetic
    // shift rounds toward minus infinity, as the datapath does.
    function automatic longint weighted(input weight_t w, input sample_t x);
        longint p;
        p = longint'(w) * longint'(x);
        return p >>> FRAC_SHIFT;
    endfunction

    // Forms the forecast for one accepted sample from the history as it stood
    // before that sample, then pushes the new differenced value and error into
    // the stores.
    function automatic forecast_t predict_forecast(input sample_t raw);
        forecast_t f;
        sample_t   diff;
        sample_t   err;
        longint    acc;
        logic      diff_clip;
        logic      pred_clip;
        logic      err_clip;
        // A clipped difference is used as is but does not raise the flag.
        if (model_cfg.difference_enable)
            diff = clip16(longint'(raw) - longint'(prev_raw), diff_clip);
        else
            diff = raw;
        // The raw sample is kept even while differencing is off.
        prev_raw = raw;
        acc = longint'(model_cfg.level_offset);
        acc += weighted(model_cfg.ar_lag1, diff_hist[0]);
        acc += weighted(model_cfg.ar_lag2, diff_hist[1]);
        acc += weighted(model_cfg.ma_lag1, err_hist[0]);
        acc += weighted(model_cfg.ma_lag2, err_hist[1]);
        acc += weighted(model_cfg.seasonal_ar_weight, season_diff_mem[season_slot]);
        acc += weighted(model_cfg.seasonal_ma_weight, season_err_mem[season_slot]);
        f.prediction = clip16(acc, pred_clip);
        err = clip16(longint'(diff) - longint'(f.prediction), err_clip);
        f.saturated = pred_clip | err_clip;
        diff_hist[1] = diff_hist[0];
        diff_hist[0] = diff;
        err_hist[1]  = err_hist[0];
        err_hist[0]  = err;
        season_diff_mem[season_slot] = diff;
        season_err_mem[season_slot]  = err;
        season_slot = (season_slot + 1) % SEASON;
        return f;
    endfunction

    // Sample driver. A new sample goes out only once the current one has
    // been taken, after a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_if.valid  <= 1'b0;
            sample_if.sample <= '0;
            send_gap = 0;
        end
        else if (!sample_if.valid || sample_if.ready)
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                sample_if.valid <= 1'b0;
            end
            else if (samples_to_send.size() > 0)
            begin
                sample_if.valid  <= 1'b1;
                sample_if.sample <= samples_to_send.pop_front();
                send_gap = in_steady ? 0 : idle_len();
            end
            else
            begin
                sample_if.valid <= 1'b0;
            end
        end
    end

    // Forecast receiver: ready drops for random stretches.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forecast_if.ready <= 1'b0;
            recv_stall = 0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall = recv_stall - 1;
            forecast_if.ready <= 1'b0;
        end
        else
        begin
            forecast_if.ready <= 1'b1;
            recv_stall = out_steady ? 0 : idle_len();
        end
    end

    // Input monitor: tracks register writes and predicts the forecast for
    // every accepted sample transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_cfg = '{RST_AR_LAG1, RST_AR_LAG2, RST_MA_LAG1, RST_MA_LAG2,
                          RST_SEASONAL_AR, RST_SEASONAL_MA, RST_LEVEL, RST_DIFF_EN};
            prev_raw    = '0;
            diff_hist   = '{default: '0};
            err_hist    = '{default: '0};
            season_diff_mem = '{default: '0};
            season_err_mem  = '{default: '0};
            season_slot = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_AR_LAG1:     model_cfg.ar_lag1            = cfg_wdata;
                    REG_AR_LAG2:     model_cfg.ar_lag2            = cfg_wdata;
                    REG_MA_LAG1:     model_cfg.ma_lag1            = cfg_wdata;
                    REG_MA_LAG2:     model_cfg.ma_lag2            = cfg_wdata;
                    REG_SEASONAL_AR: model_cfg.seasonal_ar_weight = cfg_wdata;
                    REG_SEASONAL_MA: model_cfg.seasonal_ma_weight = cfg_wdata;
                    REG_LEVEL:       model_cfg.level_offset       = cfg_wdata;
                    REG_DIFF_EN:     model_cfg.difference_enable  = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (sample_if.valid && sample_if.ready)
                forecasts_due.push_back(predict_forecast(sample_if.sample));
        end
    end

    // Output monitor: every forecast transaction is matched against the
    // oldest prediction, field by field. Only the first mismatches are
    // printed so a broken build cannot flood the log.
    always @(posedge clk)
    begin : check_forecast
        forecast_t want;
        if (rst_n && forecast_if.valid && forecast_if.ready)
        begin
            if (forecasts_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 30)
                    $display("%0t: unexpected forecast, expected none, got %0d/%0b",
                             $time, forecast_if.prediction, forecast_if.saturated);
            end
            else
            begin
                want = forecasts_due.pop_front();
                forecasts_checked++;
                if (forecast_if.saturated === 1'b1)
                    clipped_seen++;
                if (forecast_if.prediction !== want.prediction)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 30)
                        $display("%0t: prediction mismatch, expected %0d, got %0d",
                                 $time, want.prediction, forecast_if.prediction);
                end
                if (forecast_if.saturated !== want.saturated)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 30)
                        $display("%0t: saturated flag mismatch, expected %0b, got %0b",
                                 $time, want.saturated, forecast_if.saturated);
                end
            end
        end
    end

    // Register writes go out on consecutive edges; write enable stays high
    // across a burst and is lowered once at its end.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    task automatic program_settings(input cfg_t c);
        write_reg(REG_AR_LAG1, c.ar_lag1);
        write_reg(REG_AR_LAG2, c.ar_lag2);
        write_reg(REG_MA_LAG1, c.ma_lag1);
        write_reg(REG_MA_LAG2, c.ma_lag2);
        write_reg(REG_SEASONAL_AR, c.seasonal_ar_weight);
        write_reg(REG_SEASONAL_MA, c.seasonal_ma_weight);
        write_reg(REG_LEVEL, c.level_offset);
        write_reg(REG_DIFF_EN, {{(CFG_DATA_W-1){1'b0}}, c.difference_enable});
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // Registers may only change with nothing in flight. Since every sample
    // yields exactly one forecast, the block is idle once nothing is queued,
    // nothing is offered and nothing is owed. Checked on the falling edge,
    // when all rising-edge activity has settled.
    task automatic wait_idle();
        do @(negedge clk);
        while (samples_to_send.size() != 0 || sample_if.valid || forecasts_due.size() != 0);
    endtask

    function automatic weight_t pick_weight();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6) return 16'sh7FFF;
        if (r < 12) return 16'sh8000;
        if (r < 16) return '0;
        if (r < 70) return weight_t'(int'($urandom_range(0, 16384)) - 8192);
        return weight_t'($urandom);
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.ar_lag1            = pick_weight();
        c.ar_lag2            = pick_weight();
        c.ma_lag1            = pick_weight();
        c.ma_lag2            = pick_weight();
        c.seasonal_ar_weight = pick_weight();
        c.seasonal_ma_weight = pick_weight();
        c.level_offset       = pick_weight();
        c.difference_enable  = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // Most samples follow a slow random walk plus a seasonal shape, as a real
    // sensor would; the rest are full-range noise, rail values and small jitter.
    function automatic sample_t series_value();
        int unsigned r;
        int          v;
        r = $urandom_range(0, 99);
        series_tick++;
        if (r < 55)
        begin
            walk_level += int'($urandom_range(0, 512)) - 256;
            if (walk_level > 24000) walk_level = 24000;
            if (walk_level < -24000) walk_level = -24000;
            v = walk_level + season_shape[series_tick % SEASON];
            return sample_t'(v);
        end
        if (r < 78) return sample_t'($urandom);
        if (r < 88)
        begin
            case ($urandom_range(0, 4))
                0: return 16'sh7FFF;
                1: return 16'sh8000;
                2: return 16'sh0000;
                3: return 16'shFFFF;
                default: return 16'sh0001;
            endcase
        end
        return sample_t'(int'($urandom_range(0, 511)) - 256);
    endfunction

    initial
    begin : stimulus
        cfg_t        c;
        int unsigned random_sent;
        int unsigned phase_len;
        int          k;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_AR_LAG1;
        cfg_wdata         = '0;
        in_steady         = 1'b0;
        out_steady        = 1'b0;
        mismatch_count    = 0;
        forecasts_checked = 0;
        clipped_seen      = 0;
        samples_queued    = 0;
        settings_count    = 0;
        walk_level        = 0;
        series_tick       = 0;
        random_sent       = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings with differencing on. Rail-to-rail steps overflow
        // the difference in both directions; fourteen samples carry the
        // seasonal lookback past its first wrap.
        samples_to_send = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                            16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA, 16'sh0100,
                            16'shFF00, 16'sh0000, 16'sh0080, 16'sh1000};
        samples_queued += 14;
        wait_idle();

        // Every weight and the intercept at the positive rail with
        // differencing off: the forecast pins high and a negative-rail
        // sample makes the error clip.
        c = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
              16'sh7FFF, 1'b0};
        program_settings(c);
        @(negedge clk);
        samples_to_send = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh8000,
                            16'sh7FFF};
        samples_queued += 6;
        wait_idle();

        // Everything at the negative rail, differencing back on. The first
        // difference uses the raw sample kept while differencing was off.
        c = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh8000, 1'b1};
        program_settings(c);
        @(negedge clk);
        samples_to_send = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh7FFF};
        samples_queued += 4;
        wait_idle();

        // Random phases: a fresh register set, idling mode and series shape
        // each time. The first one returns to the reset settings.
        k = 0;
        while (random_sent < 1950)
        begin
            if (k == 0)
                c = '{RST_AR_LAG1, RST_AR_LAG2, RST_MA_LAG1, RST_MA_LAG2,
                      RST_SEASONAL_AR, RST_SEASONAL_MA, RST_LEVEL, RST_DIFF_EN};
            else
                c = random_settings();
            program_settings(c);
            @(negedge clk);
            in_steady  = ($urandom_range(0, 3) == 0);
            out_steady = ($urandom_range(0, 3) == 0);
            for (int s = 0; s < SEASON; s++)
                season_shape[s] = int'($urandom_range(0, 4095)) - 2048;
            phase_len = $urandom_range(200, 290);
            for (int n = 0; n < phase_len; n++)
                samples_to_send.push_back(series_value());
            samples_queued += phase_len;
            random_sent    += phase_len;
            wait_idle();
            k++;
        end

        // Let a few more cycles pass so a stray forecast would be caught.
        repeat (8) @(posedge clk);
        if (forecasts_due.size() != 0)
            mismatch_count++;

        $display("Ran %0d samples under %0d register settings after reset.",
                 samples_queued, settings_count);
        $display("Checked %0d forecasts, %0d of them flagged as clipped.",
                 forecasts_checked, clipped_seen);
        if (mismatch_count == 0)
            $display("arima_one_step_predictor verification clean");
        else
            $display("arima_one_step_predictor verification failed");
        $finish;
    end

    // Watchdog, sized well beyond the slowest legal run with the longest
    // gaps and stalls on every transaction.
    initial
    begin
        #10_000_000;
        $display("Timed out waiting for the predictor to finish.");
        $display("arima_one_step_predictor verification failed");
        $finish;
    end

endmodule
